[sv/nss_pkg.sv]
// Shared types, constants and helpers of the 3x3 neighbor sum stream block.
`default_nettype none

package nss_pkg;

    localparam int MAX_SIZE     = 32;
    localparam int ELEMENT_BITS = 16;
    localparam int IDX_W        = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SIZE_W       = 6;
    localparam int SUM_W        = 19;
    localparam int FIELD_IDX_W  = 5;
    localparam int OUT_DATA_W   = 32;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET      = SIZE_W'(32);
    localparam logic              REG_MATRIX_SIZE = 1'b0;

    typedef logic signed [ELEMENT_BITS-1:0] elem_t;
    typedef logic signed [SUM_W-1:0]        sum_t;
    typedef logic [IDX_W-1:0]               idx_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_READ0,
        RS_LOAD,
        RS_EMIT
    } run_state_t;

    function automatic sum_t sx(input elem_t x);
        sx = sum_t'(x);
    endfunction

endpackage

`default_nettype wire

[sv/neighbour_sum_3x3_stream.sv]
// Top level: streaming 3x3 neighbor sum over a square matrix, with line stores in RAM.
`default_nettype none

// Elements enter in raster order, one per cycle unless stalled; the result for cell
// (r-1, c-1) is formed from element (r, c) and passes the first stage, the second
// stage and the output register. Two RAM banks of MAX_SIZE entries (one per row
// parity) hold the two previous rows, each with one read and one write port per cycle.
// An element in the last column gives two results, so input stalls there. The final
// element of the matrix holds input while the bottom row is read back through the same
// RAM read ports and its row of sums is sent as one run; tlast marks the last result
// of each item and tuser the bottom-right cell. Writing matrix_size restarts the matrix
// and must happen while the block is idle. No clearing pass is needed after reset.
module neighbour_sum_3x3_stream (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // APB configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nss_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [nss_pkg::PDATA_W-1:0]       pwdata,
    output logic      [nss_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [nss_pkg::ELEMENT_BITS-1:0]  s_tdata,   // [15:0] element_value
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [nss_pkg::OUT_DATA_W-1:0]         m_tdata,   // [18:0] neighbour_sum,
                                                              // [23:19] result_row,
                                                              // [28:24] result_column
    output logic                                   m_tlast,   // last_of_run
    output logic                                   m_tuser    // end_of_matrix
);
    import nss_pkg::*;

    // Configuration and position
    logic [SIZE_W-1:0] size_reg;
    idx_t              nm1;
    idx_t              row_reg;
    idx_t              col_reg;
    logic              cfg_we;

    // Line store RAM, one bank per row parity
    elem_t bank0_mem [MAX_SIZE];
    elem_t bank1_mem [MAX_SIZE];
    elem_t rd0_reg;
    elem_t rd1_reg;
    logic  mem_ren;
    idx_t  mem_raddr;

    // First stage: item waiting for its RAM read data
    logic  p1_valid_reg;
    logic  p1_final_reg;
    idx_t  p1_row_reg;
    idx_t  p1_col_reg;
    elem_t p1_val_reg;

    // Window: columns c-1 and c of rows r-2..r
    elem_t win_reg [3][2];
    elem_t wn      [3][3];
    elem_t col_in  [3];
    sum_t  sum_a_next;
    sum_t  sum_b_next;

    // Second stage: pending results of one item
    logic a_pend_reg;
    logic b_pend_reg;
    sum_t sum_a_reg;
    sum_t sum_b_reg;
    idx_t p2_row_reg;
    idx_t p2_col_reg;

    // Bottom row run
    run_state_t run_state_reg;
    run_state_t run_state_next;
    idx_t       run_b_reg;
    elem_t      run_lt_reg;
    elem_t      run_lb_reg;
    elem_t      run_ct_reg;
    elem_t      run_cb_reg;
    logic       run_ren;
    idx_t       run_raddr;
    elem_t      rd_top;
    elem_t      rd_bot;
    elem_t      r_top;
    elem_t      r_bot;
    sum_t       run_sum;
    logic       run_idle;
    logic       run_b_last;

    // Handshake and emission control
    logic s_accept;
    logic in_final;
    logic out_load;
    logic emit_a;
    logic emit_b;
    logic emit_r;
    logic p2_empty;
    logic p2_finish;
    logic p1_adv;

    // Output register
    logic                   m_tvalid_reg;
    logic                   m_tlast_reg;
    logic                   m_tuser_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;
    sum_t                   out_sum;
    idx_t                   out_row;
    idx_t                   out_col;
    logic                   out_last;
    logic                   out_eom;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MATRIX_SIZE) begin
            prdata = PDATA_W'(size_reg);
        end
    end

    // Zero acts as one and anything above MAX_SIZE as MAX_SIZE.
    always_comb begin
        if (size_reg == '0) begin
            nm1 = '0;
        end else if (size_reg > SIZE_W'(MAX_SIZE)) begin
            nm1 = IDX_W'(MAX_SIZE - 1);
        end else begin
            nm1 = IDX_W'(size_reg - SIZE_W'(1));
        end
    end

    // Control flow
    assign run_idle   = (run_state_reg == RS_IDLE);
    assign run_b_last = (run_b_reg == nm1);
    assign out_load   = !m_tvalid_reg || m_tready;
    assign emit_a     = a_pend_reg && out_load;
    assign emit_b     = !a_pend_reg && b_pend_reg && out_load;
    assign emit_r     = !a_pend_reg && !b_pend_reg && (run_state_reg == RS_EMIT) && out_load;
    assign p2_empty   = !a_pend_reg && !b_pend_reg && run_idle;
    assign p2_finish  = (emit_a && !b_pend_reg && run_idle) || (emit_b && run_idle)
                      || (emit_r && run_b_last);
    assign p1_adv     = p1_valid_reg && (p2_empty || p2_finish);

    // The final element blocks input until its bottom row run has been read back.
    assign s_tready = run_idle && !(p1_valid_reg && p1_final_reg)
                    && (!p1_valid_reg || p1_adv);
    assign s_accept = s_tvalid && s_tready;
    assign in_final = (row_reg == nm1) && (col_reg == nm1);

    // Position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
        end else if (cfg_we) begin
            size_reg <= pwdata[SIZE_W-1:0];
            row_reg  <= '0;
            col_reg  <= '0;
        end else if (s_accept) begin
            if (in_final) begin
                row_reg <= '0;
                col_reg <= '0;
            end else if (col_reg == nm1) begin
                row_reg <= row_reg + idx_t'(1);
                col_reg <= '0;
            end else begin
                col_reg <= col_reg + idx_t'(1);
            end
        end
    end

    // Line store RAM: the read of the bank being written returns the row two above.
    assign mem_ren   = s_accept || run_ren;
    assign mem_raddr = run_idle ? col_reg : run_raddr;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (row_reg[0]) begin
                bank1_mem[col_reg] <= elem_t'(s_tdata);
            end else begin
                bank0_mem[col_reg] <= elem_t'(s_tdata);
            end
        end
        if (mem_ren) begin
            rd0_reg <= bank0_mem[mem_raddr];
            rd1_reg <= bank1_mem[mem_raddr];
        end
    end

    // First stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_final_reg <= in_final;
            p1_row_reg   <= row_reg;
            p1_col_reg   <= col_reg;
            p1_val_reg   <= elem_t'(s_tdata);
        end
    end

    // Window shift and the two sums that close on this element.
    always_comb begin
        col_in[0] = (p1_row_reg >= idx_t'(2)) ? (p1_row_reg[0] ? rd1_reg : rd0_reg) : '0;
        col_in[1] = (p1_row_reg >= idx_t'(1)) ? (p1_row_reg[0] ? rd0_reg : rd1_reg) : '0;
        col_in[2] = p1_val_reg;
        for (int k = 0; k < 3; k++) begin
            wn[k][0] = (p1_col_reg >= idx_t'(2)) ? win_reg[k][0] : '0;
            wn[k][1] = (p1_col_reg >= idx_t'(1)) ? win_reg[k][1] : '0;
            wn[k][2] = col_in[k];
        end
        sum_a_next = sx(wn[0][0]) + sx(wn[0][1]) + sx(wn[0][2])
                   + sx(wn[1][0]) + sx(wn[1][2])
                   + sx(wn[2][0]) + sx(wn[2][1]) + sx(wn[2][2]);
        sum_b_next = sx(wn[0][1]) + sx(wn[0][2]) + sx(wn[1][1])
                   + sx(wn[2][1]) + sx(wn[2][2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= '0;
                win_reg[k][1] <= '0;
            end
        end else if (p1_adv) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= wn[k][1];
                win_reg[k][1] <= wn[k][2];
            end
        end
    end

    // Second stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_pend_reg <= 1'b0;
            b_pend_reg <= 1'b0;
        end else if (p1_adv) begin
            a_pend_reg <= (p1_row_reg >= idx_t'(1)) && (p1_col_reg >= idx_t'(1));
            b_pend_reg <= (p1_row_reg >= idx_t'(1)) && (p1_col_reg == nm1);
        end else begin
            if (emit_a) begin
                a_pend_reg <= 1'b0;
            end
            if (emit_b) begin
                b_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            p2_row_reg <= p1_row_reg - idx_t'(1);
            p2_col_reg <= p1_col_reg - idx_t'(1);
        end
    end

    // Bottom row run sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_state_reg <= RS_IDLE;
        end else begin
            run_state_reg <= run_state_next;
        end
    end

    always_comb begin
        run_state_next = run_state_reg;
        case (run_state_reg)
            RS_IDLE: begin
                if (p1_adv && p1_final_reg) begin
                    run_state_next = RS_READ0;
                end
            end
            RS_READ0: run_state_next = RS_LOAD;
            RS_LOAD:  run_state_next = RS_EMIT;
            RS_EMIT: begin
                if (emit_r && run_b_last) begin
                    run_state_next = RS_IDLE;
                end
            end
            default:  run_state_next = RS_IDLE;
        endcase
    end

    always_comb begin
        run_ren   = 1'b0;
        run_raddr = '0;
        case (run_state_reg)
            RS_READ0: begin
                run_ren   = 1'b1;
                run_raddr = '0;
            end
            RS_LOAD: begin
                run_ren   = 1'b1;
                run_raddr = idx_t'(1);
            end
            RS_EMIT: begin
                run_ren   = emit_r;
                run_raddr = idx_t'({1'b0, run_b_reg} + (IDX_W + 1)'(2));
            end
            default: begin
                run_ren   = 1'b0;
                run_raddr = '0;
            end
        endcase
    end

    // Row n-1 sits in the bank of its parity, row n-2 in the other one.
    assign rd_bot = nm1[0] ? rd1_reg : rd0_reg;
    assign rd_top = nm1[0] ? rd0_reg : rd1_reg;
    assign r_bot  = run_b_last ? '0 : rd_bot;
    assign r_top  = run_b_last ? '0 : rd_top;

    always_comb begin
        run_sum = sx(run_lb_reg) + sx(r_bot);
        if (nm1 != '0) begin
            run_sum = run_sum + sx(run_lt_reg) + sx(run_ct_reg) + sx(r_top);
        end
    end

    always_ff @(posedge aclk) begin
        if (run_state_reg == RS_LOAD) begin
            run_b_reg  <= '0;
            run_lt_reg <= '0;
            run_lb_reg <= '0;
            run_ct_reg <= rd_top;
            run_cb_reg <= rd_bot;
        end else if (emit_r) begin
            run_b_reg  <= run_b_reg + idx_t'(1);
            run_lt_reg <= run_ct_reg;
            run_lb_reg <= run_cb_reg;
            run_ct_reg <= rd_top;
            run_cb_reg <= rd_bot;
        end
    end

    // Output selection and register
    always_comb begin
        out_sum  = run_sum;
        out_row  = nm1;
        out_col  = run_b_reg;
        out_last = run_b_last;
        out_eom  = run_b_last;
        if (a_pend_reg) begin
            out_sum  = sum_a_reg;
            out_row  = p2_row_reg;
            out_col  = p2_col_reg;
            out_last = !b_pend_reg && run_idle;
            out_eom  = 1'b0;
        end else if (b_pend_reg) begin
            out_sum  = sum_b_reg;
            out_row  = p2_row_reg;
            out_col  = nm1;
            out_last = run_idle;
            out_eom  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= emit_a || emit_b || emit_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_a || emit_b || emit_r) begin
            m_tdata_reg <= OUT_DATA_W'({FIELD_IDX_W'(out_col), FIELD_IDX_W'(out_row),
                                        out_sum});
            m_tlast_reg <= out_last;
            m_tuser_reg <= out_eom;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[sv/nss_checker.sv]
// Port-level checks of the neighbor sum stream block and their bind to the top level.
`default_nettype none

module nss_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [nss_pkg::OUT_DATA_W-1:0]     m_tdata,
    input wire logic                               m_tlast,
    input wire logic                               m_tuser
);
    import nss_pkg::*;

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result changed");

    // The bottom-right cell always closes the run of the final element.
    a_eom_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of matrix without last of run");

    // The bottom-right cell sits on the diagonal.
    a_eom_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[23:19] == m_tdata[28:24])
        else $error("end of matrix off the diagonal");

endmodule

bind neighbour_sum_3x3_stream nss_checker u_nss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench of the streaming 3x3 neighbor sum block, with its own predictor.
`timescale 1ns / 1ps

module testbench;
    import nss_pkg::*;

    localparam int RANDOM_ITEMS    = 330;
    localparam int CALM_FROM       = 270;
    localparam int SETTLE_CYCLES   = MAX_SIZE + 8;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int SPARE_REG_INDEX = 1;

    typedef struct {
        sum_t                   sum;
        logic [FIELD_IDX_W-1:0] row;
        logic [FIELD_IDX_W-1:0] col;
        logic                   last_run;
        logic                   end_mat;
    } cell_sum_t;

    // Tracks matrix position, line stores and window, and queues the sums
    // that the block owes.
    class moore_sum_predictor;
        logic [SIZE_W-1:0] size_reg;
        elem_t             lines[2][MAX_SIZE];
        elem_t             win[3][3];
        int                row_pos;
        int                col_pos;
        cell_sum_t         owed_sums[$];
        int                mismatches;

        function new();
            size_reg   = SIZE_RESET;
            row_pos    = 0;
            col_pos    = 0;
            mismatches = 0;
            foreach (lines[i, j]) lines[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
        endfunction

        function int eff_size();
            if (size_reg < 1) return 1;
            if (size_reg > MAX_SIZE) return MAX_SIZE;
            return int'(size_reg);
        endfunction

        function int pending();
            return owed_sums.size();
        endfunction

        // A size write restarts the matrix; the line stores keep stale data,
        // which is never read before it is overwritten.
        function void set_size(logic [SIZE_W-1:0] value);
            size_reg = value;
            row_pos  = 0;
            col_pos  = 0;
            foreach (win[i, j]) win[i][j] = '0;
        endfunction

        function elem_t line_at(int row, int col);
            return lines[row & 1][col];
        endfunction

        function cell_sum_t make_sum(int s, int row, int col, logic eom);
            cell_sum_t e;
            e.sum      = sum_t'(s);
            e.row      = FIELD_IDX_W'(row);
            e.col      = FIELD_IDX_W'(col);
            e.last_run = 1'b0;
            e.end_mat  = eom;
            return e;
        endfunction

        function void take_element(elem_t v);
            int        n;
            int        r;
            int        c;
            int        s;
            elem_t     col_in[3];
            cell_sum_t batch[$];

            n = eff_size();
            if (row_pos >= n || col_pos >= n) begin
                row_pos = 0;
                col_pos = 0;
            end
            r = row_pos;
            c = col_pos;

            col_in[0] = (r >= 2) ? line_at(r, c) : elem_t'(0);
            col_in[1] = (r >= 1) ? line_at(r + 1, c) : elem_t'(0);
            col_in[2] = v;
            for (int k = 0; k < 3; k++) begin
                win[k][0] = (c >= 2) ? win[k][1] : elem_t'(0);
                win[k][1] = (c >= 1) ? win[k][2] : elem_t'(0);
                win[k][2] = col_in[k];
            end
            lines[r & 1][c] = v;

            if (r >= 1 && c >= 1) begin
                s = 0;
                for (int k = 0; k < 3; k++)
                    for (int j = 0; j < 3; j++)
                        s += int'(win[k][j]);
                s -= int'(win[1][1]);
                batch.push_back(make_sum(s, r - 1, c - 1, 1'b0));
            end
            // The cell in the last column has no right neighbors, so it is
            // finished together with its left neighbor.
            if (r >= 1 && c == n - 1) begin
                s = int'(win[0][1]) + int'(win[0][2]) + int'(win[1][1])
                  + int'(win[2][1]) + int'(win[2][2]);
                batch.push_back(make_sum(s, r - 1, n - 1, 1'b0));
            end
            if (r == n - 1 && c == n - 1) begin
                for (int b = 0; b < n; b++) begin
                    s = 0;
                    if (b >= 1) s += int'(line_at(n - 1, b - 1));
                    if (b + 1 < n) s += int'(line_at(n - 1, b + 1));
                    if (n >= 2) begin
                        s += int'(line_at(n - 2, b));
                        if (b >= 1) s += int'(line_at(n - 2, b - 1));
                        if (b + 1 < n) s += int'(line_at(n - 2, b + 1));
                    end
                    batch.push_back(make_sum(s, n - 1, b, b == n - 1));
                end
                row_pos = 0;
                col_pos = 0;
            end else if (c == n - 1) begin
                row_pos = r + 1;
                col_pos = 0;
            end else begin
                col_pos = c + 1;
            end

            foreach (batch[i]) begin
                cell_sum_t e;
                e = batch[i];
                e.last_run = (i == batch.size() - 1);
                owed_sums.push_back(e);
            end
        endfunction

        function void check_sum(logic [OUT_DATA_W-1:0] data, logic last, logic eom);
            cell_sum_t e;
            sum_t      got_sum;
            logic [FIELD_IDX_W-1:0] got_row;
            logic [FIELD_IDX_W-1:0] got_col;

            got_sum = sum_t'(data[SUM_W-1:0]);
            got_row = data[SUM_W +: FIELD_IDX_W];
            got_col = data[SUM_W + FIELD_IDX_W +: FIELD_IDX_W];
            if (owed_sums.size() == 0) begin
                $error("result item with none owed: sum %0d row %0d column %0d",
                       got_sum, got_row, got_col);
                mismatches++;
                return;
            end
            e = owed_sums.pop_front();
            if (got_sum !== e.sum) begin
                $error("neighbour_sum: expected %0d, got %0d", e.sum, got_sum);
                mismatches++;
            end
            if (got_row !== e.row) begin
                $error("result_row: expected %0d, got %0d", e.row, got_row);
                mismatches++;
            end
            if (got_col !== e.col) begin
                $error("result_column: expected %0d, got %0d", e.col, got_col);
                mismatches++;
            end
            if (last !== e.last_run) begin
                $error("last_of_run: expected %0b, got %0b", e.last_run, last);
                mismatches++;
            end
            if (eom !== e.end_mat) begin
                $error("end_of_matrix: expected %0b, got %0b", e.end_mat, eom);
                mismatches++;
            end
        endfunction
    endclass

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [PADDR_W-1:0]      paddr    = '0;
    logic [PDATA_W-1:0]      pwdata   = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [ELEMENT_BITS-1:0] s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tlast;
    logic                    m_tuser;

    moore_sum_predictor sums = new();
    bit  idle_on    = 1'b1;
    int  stall_left = 0;
    int  cycles     = 0;

    neighbour_sum_3x3_stream DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("neighbour_sum_3x3_stream verification failed");
            $finish;
        end
    end

    // Result side: check each accepted item, then decide the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sums.check_sum(m_tdata, m_tlast, m_tuser);
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic elem_t pick_element();
        case ($urandom_range(0, 9))
            0:       return elem_t'(-32768);
            1:       return elem_t'(32767);
            2, 3:    return elem_t'(int'($urandom_range(0, 16)) - 8);
            default: return elem_t'($urandom);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 15))
            0:       return SIZE_W'(0);
            1:       return SIZE_W'(1);
            2:       return SIZE_W'(MAX_SIZE);
            3:       return SIZE_W'(MAX_SIZE + 1);
            4:       return '1;
            5:       return SIZE_W'($urandom_range(9, MAX_SIZE - 1));
            default: return SIZE_W'($urandom_range(2, 8));
        endcase
    endfunction

    task automatic send_element(input elem_t v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        sums.take_element(v);
    endtask

    task automatic wait_idle();
        while (sums.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input int index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * index);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == int'(REG_MATRIX_SIZE))
            sums.set_size(value[SIZE_W-1:0]);
    endtask

    task automatic configure_size(input logic [SIZE_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        write_register(int'(REG_MATRIX_SIZE), PDATA_W'(value));
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(4 * int'(REG_MATRIX_SIZE));
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== PDATA_W'(value)) begin
            $error("matrix_size readback: expected %0d, got %0d", value, readback);
            sums.mismatches++;
        end
    endtask

    initial begin
        int n;
        int count;
        int random_items;
        bit quiet;

        random_items = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Size zero behaves as a single cell: every item is a whole matrix.
        configure_size(SIZE_W'(0));
        send_element(elem_t'(-32768));
        send_element(elem_t'(32767));
        s_tvalid <= 1'b0;
        wait_idle();
        configure_size(SIZE_W'(2));
        send_element(elem_t'(32767));
        send_element(elem_t'(-32768));
        send_element(elem_t'(1));
        send_element(elem_t'(-1));
        s_tvalid <= 1'b0;
        wait_idle();
        // The center cell of a full 3x3 reaches the low end of the sum range and comes close to its top.
        configure_size(SIZE_W'(3));
        repeat (9) send_element(elem_t'(-32768));
        repeat (9) send_element(elem_t'(32767));
        s_tvalid <= 1'b0;

        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            quiet   = ($urandom_range(0, 3) == 0);
            idle_on = !(quiet || random_items >= CALM_FROM);
            if ($urandom_range(0, 5) == 0) begin
                // Unmapped register: the matrix in progress must carry on.
                write_register(SPARE_REG_INDEX, $urandom);
                count = $urandom_range(5, 40);
            end else begin
                configure_size(pick_size());
                n = sums.eff_size();
                if (n <= 10) begin
                    count = n * n * ((n <= 4) ? $urandom_range(1, 3) : 1);
                    if (n > 1 && $urandom_range(0, 1) == 1)
                        count += $urandom_range(1, n * n - 1);
                end else begin
                    count = $urandom_range(2 * n + 2, 3 * n);
                end
            end
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;
            repeat (count) begin
                if (random_items >= CALM_FROM)
                    idle_on = 1'b0;
                send_element(pick_element());
                random_items++;
            end
            s_tvalid <= 1'b0;
        end

        while (sums.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sums.mismatches == 0)
            $display("neighbour_sum_3x3_stream verification clean");
        else
            $display("neighbour_sum_3x3_stream verification failed");
        $finish;
    end

endmodule
